@@ design/tec_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch event calibrator package
// Shared constants, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tec_pkg;

  localparam int unsigned TypeW  = 16;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned RawW   = 16;
  localparam int unsigned PosW   = 13;
  localparam int unsigned ProdW  = RawW + PosW;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivSteps = PosW;
  localparam int unsigned CntW   = $clog2(DivSteps);

  // Event encodings.
  localparam logic [TypeW-1:0] EvtKey   = 16'd1;
  localparam logic [TypeW-1:0] EvtAbs   = 16'd3;
  localparam logic [CodeW-1:0] AxisX    = 16'd0;
  localparam logic [CodeW-1:0] AxisY    = 16'd1;
  localparam logic [CodeW-1:0] KeyTouch = 16'd330;
  localparam logic [ValueW-1:0] KeyPressed = 32'd1;

  // Touch kinds carried in a result beat.
  localparam logic KindPress   = 1'b0;
  localparam logic KindRelease = 1'b1;

  // Register reset values.
  localparam logic [RawW-1:0] XMinRst = 16'd0;
  localparam logic [RawW-1:0] XMaxRst = 16'd4095;
  localparam logic [RawW-1:0] YMinRst = 16'd0;
  localparam logic [RawW-1:0] YMaxRst = 16'd4095;
  localparam logic [PosW-1:0] WidthRst  = 13'd800;
  localparam logic [PosW-1:0] HeightRst = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_MIN  = 3'd0,
    CFG_X_MAX  = 3'd1,
    CFG_Y_MIN  = 3'd2,
    CFG_Y_MAX  = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP_X,
    S_MUL_X,
    S_DIV_X,
    S_CLAMP_Y,
    S_MUL_Y,
    S_DIV_Y,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;    // take the input beat
    logic clamp;     // clamp the raw reading of the selected axis
    logic mul;       // scale the clamped offset by the screen span
    logic div_step;  // one restoring division step
    logic axis_y;    // selected axis: 0 = X, 1 = Y
    logic emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic press;     // input beat is a touch-key press
    logic release_k; // input beat is a touch-key release
    logic div_last;  // current division step is the last one
    logic out_free;  // output register can take a new result
  } status_t;

endpackage

@@ design/tec_ctrl.sv @@
// ----------------------------------------------------------------------------
// Touch event calibrator controller
// Sequences input acceptance, the per-axis clamp, multiply and division steps,
// and the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module tec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tec_pkg::status_t  status,
  output tec_pkg::cmd_t     cmd
);
  import tec_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.press) begin
            state_next = S_CLAMP_X;
          end else if (status.release_k) begin
            state_next = S_EMIT;
          end
        end
      end
      S_CLAMP_X: begin
        cmd.clamp  = 1'b1;
        state_next = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_X;
      end
      S_DIV_X: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CLAMP_Y;
        end
      end
      S_CLAMP_Y: begin
        cmd.clamp  = 1'b1;
        cmd.axis_y = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul    = 1'b1;
        cmd.axis_y = 1'b1;
        state_next = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.div_step = 1'b1;
        cmd.axis_y   = 1'b1;
        if (status.div_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/tec_dp.sv @@
// ----------------------------------------------------------------------------
// Touch event calibrator datapath
// Holds the calibration registers, raw and mapped coordinates, one shared
// clamp, multiply and restoring divider, and the output register.
// ----------------------------------------------------------------------------
module tec_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tec_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tec_pkg::CfgW-1:0]      cfg_data,
  input  logic [tec_pkg::TypeW-1:0]     event_type,
  input  logic [tec_pkg::CodeW-1:0]     event_code,
  input  logic [tec_pkg::ValueW-1:0]    event_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          touch_kind,
  output logic [tec_pkg::PosW-1:0]      x_pos,
  output logic [tec_pkg::PosW-1:0]      y_pos,
  input  tec_pkg::cmd_t                 cmd,
  output tec_pkg::status_t              status
);
  import tec_pkg::*;

  logic [RawW-1:0]   x_min, x_max, y_min, y_max;
  logic [PosW-1:0]   width, height;
  logic [ValueW-1:0] raw_x, raw_y;
  logic [PosW-1:0]   mapped_x, mapped_y;
  logic              kind;

  logic [RawW-1:0]   offset;
  logic [RawW-1:0]   divisor;
  logic              empty;
  logic [RawW-1:0]   rem;
  logic [PosW-1:0]   quo;
  logic [CntW-1:0]   cnt;

  logic [ValueW-1:0] sel_raw;
  logic [RawW-1:0]   sel_lo, sel_hi;
  logic [PosW-1:0]   sel_span;
  logic [RawW-1:0]   clamped;
  logic [ProdW-1:0]  prod;
  logic [RawW:0]     trial;
  logic              fits;
  logic [RawW-1:0]   rem_next;
  logic [PosW-1:0]   quo_next;
  logic              is_touch_key;

  // Decode of the offered beat.
  assign is_touch_key    = (event_type == EvtKey) && (event_code == KeyTouch);
  assign status.press    = is_touch_key && (event_value == KeyPressed);
  assign status.release_k = is_touch_key && (event_value != KeyPressed);
  assign status.div_last = (cnt == CntW'(DivSteps - 1));
  assign status.out_free = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min  <= XMinRst;
      x_max  <= XMaxRst;
      y_min  <= YMinRst;
      y_max  <= YMaxRst;
      width  <= WidthRst;
      height <= HeightRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_MIN:  x_min  <= cfg_data;
        CFG_X_MAX:  x_max  <= cfg_data;
        CFG_Y_MIN:  y_min  <= cfg_data;
        CFG_Y_MAX:  y_max  <= cfg_data;
        CFG_WIDTH:  width  <= cfg_data[PosW-1:0];
        CFG_HEIGHT: height <= cfg_data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Axis selection for the shared arithmetic.
  always_comb begin
    if (cmd.axis_y) begin
      sel_raw  = raw_y;
      sel_lo   = y_min;
      sel_hi   = y_max;
      sel_span = height;
    end else begin
      sel_raw  = raw_x;
      sel_lo   = x_min;
      sel_hi   = x_max;
      sel_span = width;
    end
  end

  always_comb begin
    if (sel_raw < ValueW'(sel_lo)) begin
      clamped = sel_lo;
    end else if (sel_raw > ValueW'(sel_hi)) begin
      clamped = sel_hi;
    end else begin
      clamped = sel_raw[RawW-1:0];
    end
  end

  assign prod = ProdW'(offset) * ProdW'(sel_span);

  // The quotient never exceeds the span, so the upper product bits are
  // already below the divisor and only PosW steps are needed.
  assign trial    = {rem, quo[PosW-1]} - {1'b0, divisor};
  assign fits     = !trial[RawW];
  assign rem_next = fits ? trial[RawW-1:0] : {rem[RawW-2:0], quo[PosW-1]};
  assign quo_next = {quo[PosW-2:0], fits};

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      offset  <= clamped - sel_lo;
      divisor <= sel_hi - sel_lo;
      empty   <= (sel_hi <= sel_lo);
    end
    if (cmd.mul) begin
      rem <= prod[ProdW-1:PosW];
      quo <= prod[PosW-1:0];
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mul) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CntW'(1);
    end
  end

  // Coordinate state.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_x    <= '0;
      raw_y    <= '0;
      mapped_x <= '0;
      mapped_y <= '0;
      kind     <= KindPress;
    end else begin
      if (cmd.accept) begin
        kind <= status.press ? KindPress : KindRelease;
        if (event_type == EvtAbs && event_code == AxisX) begin
          raw_x <= event_value;
        end else if (event_type == EvtAbs && event_code == AxisY) begin
          raw_y <= event_value;
        end
      end
      if (cmd.div_step && status.div_last) begin
        if (cmd.axis_y) begin
          mapped_y <= empty ? '0 : quo_next;
        end else begin
          mapped_x <= empty ? '0 : quo_next;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      touch_kind <= kind;
      x_pos      <= mapped_x;
      y_pos      <= mapped_y;
    end
  end

endmodule

@@ design/touch_event_calibrator.sv @@
// ----------------------------------------------------------------------------
// Touch event calibrator
// Flow: a release beat goes straight from the idle state to the output load; a
// press runs two clamps, two multiplies, two 13-step divisions and the output
// load. The output load waits while the output register still holds a result.
// Throughput: one beat per cycle for axis and ignored events in the idle state;
// a release or press holds the input off until its result is loaded.
// Reset: synchronous; registers return to their defaults, coordinates clear.
// ----------------------------------------------------------------------------
module touch_event_calibrator (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [tec_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tec_pkg::CfgW-1:0]      cfg_data,
  // Input event channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tec_pkg::TypeW-1:0]     event_type,
  input  logic [tec_pkg::CodeW-1:0]     event_code,
  input  logic [tec_pkg::ValueW-1:0]    event_value,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          touch_kind,
  output logic [tec_pkg::PosW-1:0]      x_pos,
  output logic [tec_pkg::PosW-1:0]      y_pos
);
  import tec_pkg::*;

  // The controller steps through the clamp, multiply and division of each
  // axis in turn. Axis events are stored straight away in the idle state,
  // which they do not leave. A result sits in the output register until it
  // is taken, while the controller is already free to accept the next beat;
  // only a second result waits for the register to drain.
  cmd_t    cmd;
  status_t status;

  tec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath maps each axis as ((clamp(r) - lo) * span) / (hi - lo),
  // with a truncating quotient and zero whenever the raw range is empty.
  tec_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .touch_kind  (touch_kind),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

@@ tb/touch_event_calibrator_test.sv @@
// ----------------------------------------------------------------------------
// Touch event calibrator testbench
// Feeds event beats from a queue through a bursty driver, mirrors the block's
// coordinate latching, clamping and screen scaling in a local calibration
// model, and checks every result beat against the oldest predicted touch.
// Several calibration settings are visited, the extremes among them, and the
// result side is throttled, once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module touch_event_calibrator_test;
  import tec_pkg::*;

  // Register indexes past the end of the list; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;

  // Encodings the block must pass over without effect, and two release values.
  localparam logic [TypeW-1:0]  TypeOther   = 16'd0;
  localparam logic [CodeW-1:0]  AxisOther   = 16'd2;
  localparam logic [CodeW-1:0]  KeyOther    = 16'd331;
  localparam logic [ValueW-1:0] KeyReleased = 32'd0;
  localparam logic [ValueW-1:0] KeyRepeat   = 32'd2;

  // A press runs both clamps, multiplies and divisions in the block; allow a
  // little on top before the registers are touched or the run is closed.
  localparam int DrainCycles  = 40;
  localparam int HoldCycles   = 600;
  localparam int HoldPhase    = 6;
  localparam int RandomPhases = 8;
  localparam int PhaseEvents  = 205;
  localparam int CycleLimit   = 1000000;
  localparam int ReportLimit  = 60;

  typedef struct {
    logic [TypeW-1:0]  etype;
    logic [CodeW-1:0]  ecode;
    logic [ValueW-1:0] evalue;
  } event_beat_t;

  typedef struct {
    logic            kind;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } touch_t;

  // The receiver's stall patterns.
  typedef enum logic [1:0] {
    RX_READY,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [TypeW-1:0]   event_type  = '0;
  logic [CodeW-1:0]   event_code  = '0;
  logic [ValueW-1:0]  event_value = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               touch_kind;
  logic [PosW-1:0]    x_pos;
  logic [PosW-1:0]    y_pos;

  // Beats waiting for the driver, and touches waiting for the block.
  event_beat_t pending_events[$];
  touch_t      expected_touches[$];

  // Local copy of the calibration registers.
  logic [RawW-1:0] cal_x_min  = XMinRst;
  logic [RawW-1:0] cal_x_max  = XMaxRst;
  logic [RawW-1:0] cal_y_min  = YMinRst;
  logic [RawW-1:0] cal_y_max  = YMaxRst;
  logic [PosW-1:0] cal_width  = WidthRst;
  logic [PosW-1:0] cal_height = HeightRst;

  // Local copy of the touch state.
  logic [ValueW-1:0] raw_x_q      = '0;
  logic [ValueW-1:0] raw_y_q      = '0;
  logic [PosW-1:0]   mapped_x_q   = '0;
  logic [PosW-1:0]   mapped_y_q   = '0;
  logic              touch_down_q = 1'b0;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int phase_id       = 0;

  touch_event_calibrator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .touch_kind  (touch_kind),
    .x_pos       (x_pos),
    .y_pos       (y_pos)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calibration model
  // --------------------------------------------------------------------------

  // Clamps a raw reading into [lo, hi] and scales the offset onto the span,
  // truncating. An empty or inverted raw range maps everything to zero. The
  // reading is a full 32-bit unsigned number, so a negative one lands on hi.
  function automatic logic [PosW-1:0] map_axis(input logic [ValueW-1:0] raw,
                                               input logic [RawW-1:0] lo,
                                               input logic [RawW-1:0] hi,
                                               input logic [PosW-1:0] span);
    logic [ValueW-1:0] clamped;
    logic [63:0]       offset;
    logic [63:0]       prod;
    logic [63:0]       quot;
    if (hi <= lo) return '0;
    clamped = raw;
    if (clamped < {16'd0, lo}) clamped = {16'd0, lo};
    if (clamped > {16'd0, hi}) clamped = {16'd0, hi};
    offset = {32'd0, clamped} - {48'd0, lo};
    prod   = offset * {51'd0, span};
    quot   = prod / ({48'd0, hi} - {48'd0, lo});
    return quot[PosW-1:0];
  endfunction

  // Applies one accepted event beat to the local state and queues the touch
  // that it causes, if any.
  task automatic track_event(input logic [TypeW-1:0] etype,
                             input logic [CodeW-1:0] ecode,
                             input logic [ValueW-1:0] evalue);
    touch_t touch;
    if (etype == EvtAbs) begin
      if (ecode == AxisX) raw_x_q = evalue;
      else if (ecode == AxisY) raw_y_q = evalue;
    end else if (etype == EvtKey && ecode == KeyTouch) begin
      if (evalue == KeyPressed) begin
        touch_down_q = 1'b1;
        mapped_x_q   = map_axis(raw_x_q, cal_x_min, cal_x_max, cal_width);
        mapped_y_q   = map_axis(raw_y_q, cal_y_min, cal_y_max, cal_height);
        touch.kind   = KindPress;
      end else begin
        // Any other key state, autorepeat included, counts as a release.
        touch_down_q = 1'b0;
        touch.kind   = KindRelease;
      end
      touch.x = mapped_x_q;
      touch.y = mapped_y_q;
      expected_touches.push_back(touch);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: takes beats from the queue and offers them in bursts. Valid is
  // only dropped once the current beat has been taken.
  // --------------------------------------------------------------------------
  event_beat_t drv_beat;
  int          burst_left = 0;
  int          gap_left   = 0;
  int          gap_roll;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        drv_beat = pending_events.pop_front();
        event_type  <= drv_beat.etype;
        event_code  <= drv_beat.ecode;
        event_value <= drv_beat.evalue;
        in_valid    <= 1'b1;
        if (burst_left <= 1) begin
          // End of a burst: half the gaps are nil so that back-to-back stretches
          // occur, most others are short and a few are long.
          burst_left <= $urandom_range(1, 30);
          gap_roll = $urandom_range(0, 9);
          if (gap_roll < 5) gap_left <= 0;
          else if (gap_roll < 9) gap_left <= $urandom_range(1, 6);
          else gap_left <= $urandom_range(10, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns every so often. In the hold
  // phase it refuses all result beats for a long stretch, so that the result
  // register fills and the block has to stall its input.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_READY;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (phase_id == HoldPhase && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_READY:  out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted event beat goes through the model, every accepted
  // result beat is compared with the oldest predicted touch.
  // --------------------------------------------------------------------------
  touch_t mon_touch;

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) track_event(event_type, event_code, event_value);
      if (out_valid && out_ready) begin
        if (expected_touches.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: result beat with none expected, actual kind %0d x %0d y %0d",
                     $time, touch_kind, x_pos, y_pos);
        end else begin
          mon_touch = expected_touches.pop_front();
          if (touch_kind !== mon_touch.kind)
            report_field("touch_kind", mon_touch.kind, touch_kind);
          if (x_pos !== mon_touch.x) report_field("x_pos", mon_touch.x, x_pos);
          if (y_pos !== mon_touch.y) report_field("y_pos", mon_touch.y, y_pos);
        end
      end
    end
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d touches outstanding", $time,
               expected_touches.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_event(input logic [TypeW-1:0] etype,
                            input logic [CodeW-1:0] ecode,
                            input logic [ValueW-1:0] evalue);
    event_beat_t beat;
    beat.etype  = etype;
    beat.ecode  = ecode;
    beat.evalue = evalue;
    pending_events.push_back(beat);
  endtask

  // Called at a rising edge; the write lands on the next one. The local copy
  // is updated at once, which is safe as the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_X_MIN:  cal_x_min  = data;
      CFG_X_MAX:  cal_x_max  = data;
      CFG_Y_MIN:  cal_y_min  = data;
      CFG_Y_MAX:  cal_y_max  = data;
      CFG_WIDTH:  cal_width  = data[PosW-1:0];
      CFG_HEIGHT: cal_height = data[PosW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until every beat has gone in and every touch has come out, then
  // lets a press worth of cycles pass; returns at a rising edge.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_touches.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Mostly in range, with the bounds themselves, one step outside them and
  // the odd full 32-bit reading, negative ones included.
  function automatic logic [ValueW-1:0] pick_raw(input logic [RawW-1:0] lo,
                                                 input logic [RawW-1:0] hi);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return {16'd0, lo};
      2:       return {16'd0, hi};
      3:       return {16'd0, lo} - 32'd1;
      4:       return {16'd0, hi} + 32'd1;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic pick_range(output logic [RawW-1:0] lo, output logic [RawW-1:0] hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = RawW'($urandom);
        hi = RawW'($urandom);
      end
      1: begin
        lo = RawW'($urandom);
        hi = lo;
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        lo = RawW'($urandom_range(0, 40000));
        hi = RawW'(lo + $urandom_range(1, 20000));
      end
    endcase
  endtask

  function automatic logic [CfgW-1:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd4096;
      2:       return CfgW'($urandom);
      default: return CfgW'($urandom_range(1, 4096));
    endcase
  endfunction

  // Mostly well-formed gestures: a few axis moves, a press, sometimes a
  // repeated press after further moves, then usually a release of some form.
  // The rest is stray key beats and noise the block must pass over; noise
  // does not count towards the total.
  task automatic push_random_events(input int count);
    int pushed;
    int moves;
    logic [ValueW-1:0] rel_value;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 99) < 75) begin
        moves = $urandom_range(1, 3);
        repeat (moves) begin
          if ($urandom_range(0, 1)) push_event(EvtAbs, AxisX, pick_raw(cal_x_min, cal_x_max));
          else push_event(EvtAbs, AxisY, pick_raw(cal_y_min, cal_y_max));
        end
        push_event(EvtKey, KeyTouch, KeyPressed);
        pushed += moves + 1;
        if ($urandom_range(0, 3) == 0) begin
          push_event(EvtAbs, AxisX, pick_raw(cal_x_min, cal_x_max));
          push_event(EvtAbs, AxisY, pick_raw(cal_y_min, cal_y_max));
          push_event(EvtKey, KeyTouch, KeyPressed);
          pushed += 3;
        end
        case ($urandom_range(0, 3))
          0, 1:    rel_value = KeyReleased;
          2:       rel_value = KeyRepeat;
          default: rel_value = $urandom;
        endcase
        if ($urandom_range(0, 5) != 0) begin
          push_event(EvtKey, KeyTouch, rel_value);
          pushed++;
        end
      end else if ($urandom_range(0, 1)) begin
        push_event(EvtKey, KeyTouch, $urandom_range(0, 1) ? KeyPressed : $urandom);
        pushed++;
      end else begin
        case ($urandom_range(0, 2))
          0:       push_event(EvtAbs, CodeW'($urandom), $urandom);
          1:       push_event(EvtKey, CodeW'($urandom), $urandom);
          default: push_event(TypeW'($urandom), CodeW'($urandom), $urandom);
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [RawW-1:0] lo;
    logic [RawW-1:0] hi;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default calibration straight after reset. A press before any axis beat
    // maps the origin; a release follows.
    push_event(EvtKey, KeyTouch, KeyPressed);
    push_event(EvtKey, KeyTouch, KeyReleased);
    // Top corner of the raw range lands on the full screen size.
    push_event(EvtAbs, AxisX, 32'd4095);
    push_event(EvtAbs, AxisY, 32'd4095);
    push_event(EvtKey, KeyTouch, KeyPressed);
    // Negative readings are huge unsigned values and clamp to the maximum;
    // a second press while already down still reports.
    push_event(EvtAbs, AxisX, 32'hFFFF_FFFF);
    push_event(EvtAbs, AxisY, 32'h8000_0000);
    push_event(EvtKey, KeyTouch, KeyPressed);
    // Autorepeat counts as a release, and a release with nothing pressed
    // still reports the last mapped position.
    push_event(EvtAbs, AxisX, 32'd2048);
    push_event(EvtAbs, AxisY, 32'h7FFF_FFFF);
    push_event(EvtKey, KeyTouch, KeyRepeat);
    push_event(EvtKey, KeyTouch, KeyReleased);
    // Unknown codes and types change nothing.
    push_event(EvtAbs, AxisOther, 32'd17);
    push_event(EvtAbs, 16'hFFFF, 32'd0);
    push_event(EvtKey, KeyOther, KeyPressed);
    push_event(TypeOther, AxisX, KeyPressed);
    push_event(16'hFFFF, KeyTouch, KeyPressed);
    push_event(EvtAbs, KeyTouch, KeyPressed);
    push_event(EvtKey, KeyTouch, KeyPressed);

    // Widest raw range on X, narrowest on Y, the largest span on Y; the height
    // write carries bits above the register width. The spare indexes must not
    // disturb anything.
    wait_drained();
    write_reg(CFG_X_MIN, 16'd0);
    write_reg(CFG_X_MAX, 16'hFFFF);
    write_reg(CFG_Y_MIN, 16'd0);
    write_reg(CFG_Y_MAX, 16'd1);
    write_reg(CFG_WIDTH, 16'd4096);
    write_reg(CFG_HEIGHT, 16'hFFFF);
    write_reg(CfgSpare6, 16'hFFFF);
    write_reg(CfgSpare7, 16'h1234);
    cfg_we   <= 1'b0;
    phase_id <= 1;
    @(negedge clk);
    push_event(EvtAbs, AxisX, 32'd65535);
    push_event(EvtAbs, AxisY, 32'd1);
    push_event(EvtKey, KeyTouch, KeyPressed);
    push_event(EvtAbs, AxisX, 32'h0000_8000);
    push_event(EvtAbs, AxisY, 32'd0);
    push_event(EvtKey, KeyTouch, KeyPressed);
    push_event(EvtKey, KeyTouch, KeyReleased);

    // Empty and inverted raw ranges map to zero whatever the span.
    wait_drained();
    write_reg(CFG_X_MIN, 16'd500);
    write_reg(CFG_X_MAX, 16'd500);
    write_reg(CFG_Y_MIN, 16'hFFFF);
    write_reg(CFG_Y_MAX, 16'd0);
    write_reg(CFG_WIDTH, 16'd4096);
    write_reg(CFG_HEIGHT, 16'd4096);
    cfg_we   <= 1'b0;
    phase_id <= 2;
    @(negedge clk);
    push_event(EvtAbs, AxisX, 32'd500);
    push_event(EvtAbs, AxisY, 32'd100);
    push_event(EvtKey, KeyTouch, KeyPressed);
    push_event(EvtKey, KeyTouch, KeyReleased);

    // Random phases, each with a fresh calibration. One of them runs with the
    // receiver held off for a long stretch at its start.
    for (int p = 3; p < 3 + RandomPhases; p++) begin
      wait_drained();
      pick_range(lo, hi);
      write_reg(CFG_X_MIN, lo);
      write_reg(CFG_X_MAX, hi);
      pick_range(lo, hi);
      write_reg(CFG_Y_MIN, lo);
      write_reg(CFG_Y_MAX, hi);
      write_reg(CFG_WIDTH, pick_span());
      write_reg(CFG_HEIGHT, pick_span());
      if ($urandom_range(0, 3) == 0) write_reg(CfgSpare6, CfgW'($urandom));
      cfg_we   <= 1'b0;
      phase_id <= p;
      @(negedge clk);
      push_random_events(PhaseEvents);
    end

    wait_drained();
    if (mismatch_count == 0 && expected_touches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ touch_event_calibrator.f @@
design/tec_pkg.sv
design/tec_ctrl.sv
design/tec_dp.sv
design/touch_event_calibrator.sv
tb/touch_event_calibrator_test.sv
